>>> src/round_robin_quantum_scheduler_assert.svh
// Assertion helpers for the scheduler checker.
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_ASSERT_SVH

// Clocked check, switched off while reset is held.
`define RRQS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("rrqs assertion failed");

// Clocked check that also holds through reset.
`define RRQS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("rrqs assertion failed");

`endif

>>> src/rrqs_pkg.sv
`timescale 1ns / 1ps
package rrqs_pkg;

	localparam int TASK_SLOTS = 16;
	localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

	localparam int OP_W    = 2;
	localparam int ID_W    = 4;
	localparam int CTX_W   = 64;
	localparam int CNT_W   = 64;
	localparam int QUANT_W = 16;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
	localparam logic [OP_W-1:0] OP_SET     = 2'd1;
	localparam logic [OP_W-1:0] OP_INSTALL = 2'd2;

	// slots that a set-state request may never touch
	localparam logic [ID_W-1:0] ID_IDLE_TASK  = ID_W'(0);
	localparam logic [ID_W-1:0] ID_FIXED_TASK = ID_W'(2);

	localparam logic [QUANT_W-1:0] QUANT_RST = QUANT_W'(10);

	// register index = paddr[2]
	localparam logic REG_ENABLE  = 1'b0;
	localparam logic REG_QUANTUM = 1'b1;

	typedef enum logic [1:0] {
		SLOT_UNUSED   = 2'd0,
		SLOT_RUNNABLE = 2'd1,
		SLOT_WAITING  = 2'd2
	} slot_st_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_UPDATE,
		S_REPORT,
		S_RESULT
	} fsm_st_t;

	typedef struct packed {
		logic capture;
		logic decide;
		logic update;
		logic report;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic               enable;
		logic [QUANT_W-1:0] quantum;
	} cfg_t;

endpackage

>>> src/rrqs_req_if.sv
`timescale 1ns / 1ps
interface rrqs_req_if import rrqs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [ID_W-1:0]  task_id;
	logic             make_runnable;
	logic [CTX_W-1:0] context_req;

	modport source (output valid, op, task_id, make_runnable, context_req, input ready);
	modport sink   (input valid, op, task_id, make_runnable, context_req, output ready);
endinterface

>>> src/rrqs_rsp_if.sv
`timescale 1ns / 1ps
interface rrqs_rsp_if import rrqs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CTX_W-1:0] resume_context;
	logic             switched;
	logic [ID_W-1:0]  current_task;
	logic             status;
	logic [CNT_W-1:0] slot_ticks;
	logic [CNT_W-1:0] slot_switches;

	modport source (output valid, resume_context, switched, current_task, status,
		slot_ticks, slot_switches, input ready);
	modport sink   (input valid, resume_context, switched, current_task, status,
		slot_ticks, slot_switches, output ready);
endinterface

>>> src/rrqs_cfg.sv
`timescale 1ns / 1ps
module rrqs_cfg import rrqs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic               enable_q;
	logic [QUANT_W-1:0] quantum_q;
	logic               wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			quantum_q <= QUANT_RST;
		end else if (wr) begin
			case (paddr[2])
				REG_ENABLE:  enable_q  <= pwdata[0];
				REG_QUANTUM: quantum_q <= pwdata[QUANT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ENABLE:  prdata = {{(DATA_W-1){1'b0}}, enable_q};
			REG_QUANTUM: prdata = {{(DATA_W-QUANT_W){1'b0}}, quantum_q};
			default:     prdata = '0;
		endcase
	end

	assign cfg.enable  = enable_q;
	assign cfg.quantum = quantum_q;

endmodule

>>> src/rrqs_ctrl.sv
`timescale 1ns / 1ps
module rrqs_ctrl import rrqs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	fsm_st_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_REPORT;
			end
			S_REPORT: begin
				cmd.report = 1'b1;
				state_d    = S_RESULT;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> src/rrqs_datapath.sv
`timescale 1ns / 1ps
module rrqs_datapath import rrqs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output stat_t            stat,
	input  cfg_t             cfg,
	input  logic [OP_W-1:0]  op,
	input  logic [ID_W-1:0]  task_id,
	input  logic             make_runnable,
	input  logic [CTX_W-1:0] context_req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output logic [CTX_W-1:0] resume_context,
	output logic             switched,
	output logic [ID_W-1:0]  current_task,
	output logic             status,
	output logic [CNT_W-1:0] slot_ticks,
	output logic [CNT_W-1:0] slot_switches
);

	// slot memories, one write and one read port each
	logic [CTX_W-1:0] ctx_mem  [TASK_SLOTS];
	logic [CNT_W-1:0] tick_mem [TASK_SLOTS];
	logic [CNT_W-1:0] sw_mem   [TASK_SLOTS];

	// per-slot flags
	slot_st_t               slot_st_q [TASK_SLOTS];
	logic [TASK_SLOTS-1:0]  ctx_nz_q;
	logic [TASK_SLOTS-1:0]  tick_vld_q;
	logic [TASK_SLOTS-1:0]  sw_vld_q;
	logic [SLOT_W-1:0]      running_q;
	logic [QUANT_W-1:0]     slice_q;
	logic                   out_valid_q;

	// captured request
	logic [OP_W-1:0]  op_q;
	logic [ID_W-1:0]  id_q;
	logic             mk_q;
	logic [CTX_W-1:0] ctx_q;

	// decision
	logic              dec_tick_q;
	logic              dec_expire_q;
	logic              dec_switch_q;
	logic [SLOT_W-1:0] nx_q;

	// read data
	logic [CNT_W-1:0] tick_rd_q;
	logic [CNT_W-1:0] sw_rd_q;
	logic             tick_vld_rd_q;
	logic             sw_vld_rd_q;
	logic [CTX_W-1:0] ctx_rd_q;

	// staged result
	logic [CTX_W-1:0] resume_q;
	logic             switched_q;
	logic             status_q;

	// output register
	logic [CTX_W-1:0] out_ctx_q;
	logic             out_sw_q;
	logic [ID_W-1:0]  out_task_q;
	logic             out_status_q;
	logic [CNT_W-1:0] out_ticks_q;
	logic [CNT_W-1:0] out_switches_q;

	logic [SLOT_W-1:0]     id_slot;
	logic                  id_ok;
	logic [TASK_SLOTS-1:0] elig;
	logic                  is_tick;
	logic [QUANT_W-1:0]    slice_inc;
	logic                  expire;
	logic                  found;
	logic [SLOT_W-1:0]     nx;
	logic [SLOT_W:0]       sum;
	logic [SLOT_W-1:0]     cand;
	logic                  set_rej;
	logic                  set_ok;
	logic                  install_ok;
	logic [SLOT_W-1:0]     cnt_raddr;
	logic [SLOT_W-1:0]     ctx_waddr;
	logic                  ctx_we;
	logic [CNT_W-1:0]      tick_cur;
	logic [CNT_W-1:0]      sw_cur;

	assign id_slot = SLOT_W'(id_q);
	assign id_ok   = 32'(id_q) < TASK_SLOTS;

	always_comb begin
		for (int i = 0; i < TASK_SLOTS; i++) begin
			elig[i] = (slot_st_q[i] == SLOT_RUNNABLE) && ((i == 0) || ctx_nz_q[i]);
		end
	end

	assign is_tick   = (op_q == OP_TICK) && (ctx_q != '0) && cfg.enable;
	assign slice_inc = slice_q + QUANT_W'(1);
	assign expire    = is_tick && (slice_inc >= cfg.quantum);

	// round-robin pick: nearest eligible slot after the running one
	always_comb begin
		found = 1'b0;
		nx    = running_q;
		sum   = '0;
		cand  = '0;
		for (int k = TASK_SLOTS - 1; k >= 1; k--) begin
			sum = {1'b0, running_q} + (SLOT_W+1)'(k);
			if (sum >= (SLOT_W+1)'(TASK_SLOTS)) begin
				sum = sum - (SLOT_W+1)'(TASK_SLOTS);
			end
			cand = sum[SLOT_W-1:0];
			if (elig[cand]) begin
				found = 1'b1;
				nx    = cand;
			end
		end
	end

	assign set_rej = (op_q == OP_SET) && (!id_ok || (id_q == ID_IDLE_TASK) ||
		(id_q == ID_FIXED_TASK) || (slot_st_q[id_slot] == SLOT_UNUSED));
	assign set_ok     = (op_q == OP_SET) && !set_rej;
	assign install_ok = (op_q == OP_INSTALL) && id_ok;

	assign cnt_raddr = cmd.report ? id_slot : running_q;
	assign ctx_waddr = dec_expire_q ? running_q : id_slot;
	assign ctx_we    = cmd.update && (dec_expire_q || install_ok);
	assign tick_cur  = tick_vld_rd_q ? tick_rd_q : '0;
	assign sw_cur    = sw_vld_rd_q ? sw_rd_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op;
			id_q  <= task_id;
			mk_q  <= make_runnable;
			ctx_q <= context_req;
		end
		if (cmd.decide) begin
			dec_tick_q   <= is_tick;
			dec_expire_q <= expire;
			dec_switch_q <= expire && found && ctx_nz_q[nx];
			nx_q         <= nx;
			ctx_rd_q     <= ctx_mem[nx];
		end
		if (cmd.decide || cmd.report) begin
			tick_rd_q     <= tick_mem[cnt_raddr];
			sw_rd_q       <= sw_mem[cnt_raddr];
			tick_vld_rd_q <= tick_vld_q[cnt_raddr];
			sw_vld_rd_q   <= sw_vld_q[cnt_raddr];
		end
		if (cmd.update) begin
			resume_q   <= dec_switch_q ? ctx_rd_q : ctx_q;
			switched_q <= dec_switch_q;
			status_q   <= set_rej;
		end
		if (cmd.load_out) begin
			out_ctx_q      <= resume_q;
			out_sw_q       <= switched_q;
			out_task_q     <= ID_W'(running_q);
			out_status_q   <= status_q;
			out_ticks_q    <= id_ok ? tick_cur : '0;
			out_switches_q <= id_ok ? sw_cur : '0;
		end
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (ctx_we) begin
			ctx_mem[ctx_waddr] <= ctx_q;
		end
		if (cmd.update && dec_tick_q) begin
			tick_mem[running_q] <= tick_cur + CNT_W'(1);
		end
		if (cmd.update && dec_switch_q) begin
			sw_mem[running_q] <= sw_cur + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				slot_st_q[i] <= (i == 0) ? SLOT_RUNNABLE : SLOT_UNUSED;
			end
			ctx_nz_q    <= '0;
			tick_vld_q  <= '0;
			sw_vld_q    <= '0;
			running_q   <= '0;
			slice_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				if (dec_tick_q) begin
					slice_q               <= dec_expire_q ? '0 : slice_inc;
					tick_vld_q[running_q] <= 1'b1;
				end
				if (dec_expire_q) begin
					ctx_nz_q[running_q] <= (ctx_q != '0);
				end
				if (dec_switch_q) begin
					sw_vld_q[running_q] <= 1'b1;
					running_q           <= nx_q;
				end
				if (set_ok) begin
					slot_st_q[id_slot] <= mk_q ? SLOT_RUNNABLE : SLOT_WAITING;
				end
				if (install_ok) begin
					slot_st_q[id_slot] <= SLOT_RUNNABLE;
					ctx_nz_q[id_slot]  <= (ctx_q != '0);
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_free = !out_valid_q || rsp_ready;

	assign rsp_valid      = out_valid_q;
	assign resume_context = out_ctx_q;
	assign switched       = out_sw_q;
	assign current_task   = out_task_q;
	assign status         = out_status_q;
	assign slot_ticks     = out_ticks_q;
	assign slot_switches  = out_switches_q;

endmodule

>>> src/round_robin_quantum_scheduler.sv
`timescale 1ns / 1ps
// The controller takes one request at a time and walks it through decide,
// update and report over the slot memories, each with one read and one write
// port, then loads the result into the output register in its result step.
// A waiting result sits in the output register; the next request is still taken
// but holds in its result step until that register frees.
// Reset (arst_n, asynchronous, active low): slot 0 runnable, other slots unused,
// counters and contexts read as zero, scheduler disabled, quantum 10.
module round_robin_quantum_scheduler import rrqs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	rrqs_req_if.sink          req,
	rrqs_rsp_if.source        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	// register file: enable at 0x0, quantum at 0x4
	rrqs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: one request in flight at a time
	rrqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// slot table, round-robin pick and output register
	rrqs_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg            (cfg),
		.op             (req.op),
		.task_id        (req.task_id),
		.make_runnable  (req.make_runnable),
		.context_req    (req.context_req),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.resume_context (rsp.resume_context),
		.switched       (rsp.switched),
		.current_task   (rsp.current_task),
		.status         (rsp.status),
		.slot_ticks     (rsp.slot_ticks),
		.slot_switches  (rsp.slot_switches)
	);

endmodule

>>> src/rrqs_checker.sv
`timescale 1ns / 1ps
`include "round_robin_quantum_scheduler_assert.svh"
module rrqs_checker import rrqs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [CTX_W-1:0]  rsp_resume_context,
	input logic              rsp_switched,
	input logic              rsp_status,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	input logic [DATA_W-1:0] prdata,
	input logic              pready
);

	// a held result does not change under stall
	`RRQS_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_resume_context))

	// one request at a time: once one is taken, ready stays low through decide, update, report and result
	`RRQS_ASSERT(a_req_gap, clk, arst_n, req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready)

	// a rejected set-state never reports a switch
	`RRQS_ASSERT(a_rej_no_sw, clk, arst_n, rsp_valid && rsp_status |-> !rsp_switched)

	// quantum write is visible on readback in the next cycle
	`RRQS_ASSERT(a_quant_rb, clk, arst_n, psel && penable && pwrite && paddr[2] |=> !paddr[2] || prdata[15:0] == $past(pwdata[15:0]))

	`RRQS_ASSERT_ALWAYS(a_pready, clk, pready)

endmodule

bind round_robin_quantum_scheduler rrqs_checker u_rrqs_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_resume_context (rsp.resume_context),
	.rsp_switched       (rsp.switched),
	.rsp_status         (rsp.status),
	.psel               (psel),
	.penable            (penable),
	.pwrite             (pwrite),
	.paddr              (paddr),
	.pwdata             (pwdata),
	.prdata             (prdata),
	.pready             (pready)
);
